### rtl/crd_pkg.sv
// Shared constants and types of the control report event decoder.
package crd_pkg;

	localparam int NUM_BUTTONS_DEF  = 48;
	localparam int NUM_ENCODERS_DEF = 8;

	localparam int BTN_W      = 48;
	localparam int ENC_PORTS  = 8;
	localparam int NUM_EVT    = ENC_PORTS + 1;
	localparam int IDX_W      = 6;
	localparam int SHIFT_BIT  = 39;

	localparam logic [7:0] MAIN_TOP    = 8'h0f;
	localparam logic [7:0] MAIN_BOTTOM = 8'h00;
	localparam logic [3:0] HIGH_WRAP   = 4'd3;

	typedef enum logic {
		KIND_BUTTON  = 1'b0,
		KIND_ENCODER = 1'b1
	} kind_t;

	typedef struct packed {
		logic [BTN_W-1:0]               button_bits;
		logic [7:0]                     main_encoder;
		logic [ENC_PORTS-1:0][15:0]     enc_pos;
	} report_t;

	typedef struct packed {
		logic                   btn_hit;
		logic [IDX_W-1:0]       btn_index;
		logic                   btn_value;
		logic [NUM_EVT-1:0]     enc_chg;
		logic [NUM_EVT-1:0]     enc_up;
		logic                   shift;
	} decode_t;

	typedef struct packed {
		kind_t              kind;
		logic [IDX_W-1:0]   index;
		logic               value;
		logic               shift;
		logic               last;
	} event_t;

endpackage

### rtl/crd_report_if.sv
// Channel interfaces: input reports and output events.
interface crd_report_if;
	logic        valid;
	logic        ready;
	logic [47:0] button_bits;
	logic [7:0]  main_encoder;
	logic [15:0] enc_pos_a;
	logic [15:0] enc_pos_b;
	logic [15:0] enc_pos_c;
	logic [15:0] enc_pos_d;
	logic [15:0] enc_pos_e;
	logic [15:0] enc_pos_f;
	logic [15:0] enc_pos_g;
	logic [15:0] enc_pos_h;

	modport source (output valid, button_bits, main_encoder, enc_pos_a, enc_pos_b,
		enc_pos_c, enc_pos_d, enc_pos_e, enc_pos_f, enc_pos_g, enc_pos_h, input ready);
	modport sink (input valid, button_bits, main_encoder, enc_pos_a, enc_pos_b,
		enc_pos_c, enc_pos_d, enc_pos_e, enc_pos_f, enc_pos_g, enc_pos_h, output ready);
endinterface

interface crd_event_if;
	logic       valid;
	logic       ready;
	logic       event_kind;
	logic [5:0] event_index;
	logic       event_value;
	logic       shift_held;
	logic       last_event;

	modport source (output valid, event_kind, event_index, event_value, shift_held,
		last_event, input ready);
	modport sink (input valid, event_kind, event_index, event_value, shift_held,
		last_event, output ready);
endinterface

### rtl/crd_decode.sv
// Known button/encoder state and the compare of one report against it.
module crd_decode #(
	parameter int NUM_BUTTONS  = crd_pkg::NUM_BUTTONS_DEF,
	parameter int NUM_ENCODERS = crd_pkg::NUM_ENCODERS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  crd_pkg::report_t rpt_s1,
	input  logic             commit,
	output crd_pkg::decode_t dec
);

	localparam int NB = (NUM_BUTTONS < crd_pkg::BTN_W) ? NUM_BUTTONS : crd_pkg::BTN_W;
	localparam logic [NB-1:0] SHIFT_MASK =
		(crd_pkg::SHIFT_BIT < NB) ? (NB'(1) << crd_pkg::SHIFT_BIT) : '0;

	logic [NB-1:0]  known_btn_q;
	logic [7:0]     known_main_q;
	logic [15:0]    known_enc_q [NUM_ENCODERS];

	logic [NB-1:0]  new_btn;
	logic [NB-1:0]  diff;
	logic [7:0]     main_nv;
	logic [7:0]     main_ov;
	logic [crd_pkg::NUM_EVT-1:0] chg;
	logic [crd_pkg::NUM_EVT-1:0] up;

	assign new_btn = rpt_s1.button_bits[NB-1:0];
	assign diff    = (new_btn ^ known_btn_q) & ~SHIFT_MASK;

	// main encoder: 15 -> 0 wraps up, 0 -> 15 wraps down
	assign main_nv = rpt_s1.main_encoder;
	assign main_ov = known_main_q;
	assign chg[0]  = (main_nv != main_ov);
	assign up[0]   = ((main_ov < main_nv) ||
		(main_ov == crd_pkg::MAIN_TOP && main_nv == crd_pkg::MAIN_BOTTOM)) &&
		!(main_ov == crd_pkg::MAIN_BOTTOM && main_nv == crd_pkg::MAIN_TOP);

	// other encoders: stored high nibble 3 -> new high byte 0 wraps up, reverse wraps down
	for (genvar e = 0; e < crd_pkg::ENC_PORTS; e++) begin : g_enc
		if (e < NUM_ENCODERS) begin : g_on
			logic [15:0] nv;
			logic [15:0] ov;
			logic [3:0]  ph;
			logic [7:0]  nh;
			assign nv = rpt_s1.enc_pos[e];
			assign ov = known_enc_q[e];
			assign ph = ov[11:8];
			assign nh = nv[15:8];
			assign chg[e+1] = (nv != ov);
			assign up[e+1]  = ((ov < nv) || (ph == crd_pkg::HIGH_WRAP && nh == 8'd0)) &&
				!(ph == 4'd0 && nh == {4'd0, crd_pkg::HIGH_WRAP});
		end else begin : g_off
			assign chg[e+1] = 1'b0;
			assign up[e+1]  = 1'b0;
		end
	end

	always_comb begin
		dec           = '0;
		dec.shift     = rpt_s1.button_bits[crd_pkg::SHIFT_BIT];
		dec.btn_hit   = |diff;
		// lowest differing button wins
		for (int i = NB - 1; i >= 0; i--) begin
			if (diff[i]) begin
				dec.btn_index = crd_pkg::IDX_W'(i);
				dec.btn_value = new_btn[i];
			end
		end
		if (!dec.btn_hit) begin
			dec.enc_chg = chg;
			dec.enc_up  = up;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			known_btn_q  <= '0;
			known_main_q <= '0;
			for (int e = 0; e < NUM_ENCODERS; e++) known_enc_q[e] <= '0;
		end else if (commit) begin
			if (dec.btn_hit) begin
				known_btn_q[dec.btn_index[$clog2(NB)-1:0]] <= dec.btn_value;
			end else begin
				// unchanged encoders just rewrite their own value
				known_main_q <= rpt_s1.main_encoder;
				for (int e = 0; e < NUM_ENCODERS; e++) known_enc_q[e] <= rpt_s1.enc_pos[e];
			end
		end
	end

	a_shift_never_reported: assert property (@(posedge clk) disable iff (!arst_n)
		dec.btn_hit |-> dec.btn_index != crd_pkg::IDX_W'(crd_pkg::SHIFT_BIT))
		else $error("shift bit decoded as button event");

	a_shift_never_stored: assert property (@(posedge clk) disable iff (!arst_n)
		(diff & SHIFT_MASK) == '0 && (known_btn_q & SHIFT_MASK) == '0)
		else $error("shift bit entered the known button state");

	a_button_blocks_encoders: assert property (@(posedge clk) disable iff (!arst_n)
		dec.btn_hit |-> dec.enc_chg == '0)
		else $error("encoder events decoded alongside a button event");

endmodule

### rtl/crd_emit.sv
// Event queue of one decoded report and the output register, one event per cycle while the sink is ready.
module crd_emit (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             load,
	input  crd_pkg::decode_t dec,
	output logic             free,
	crd_event_if.source      evt
);

	logic                        btn_pend_s2;
	logic [crd_pkg::NUM_EVT-1:0] enc_pend_s2;
	logic [crd_pkg::IDX_W-1:0]   btn_index_s2;
	logic                        btn_value_s2;
	logic [crd_pkg::NUM_EVT-1:0] enc_up_s2;
	logic                        shift_s2;

	logic                        out_valid_q;
	crd_pkg::event_t             out_q;

	logic                        busy;
	logic                        out_free;
	logic                        emit;
	logic [crd_pkg::NUM_EVT-1:0] pick;
	logic [crd_pkg::NUM_EVT-1:0] rest;
	crd_pkg::event_t             nxt;

	assign busy     = btn_pend_s2 || (|enc_pend_s2);
	assign out_free = !out_valid_q || evt.ready;
	assign emit     = busy && out_free;

	always_comb begin
		pick = '0;
		nxt  = '0;
		nxt.shift = shift_s2;
		for (int i = crd_pkg::NUM_EVT - 1; i >= 0; i--) begin
			if (enc_pend_s2[i]) begin
				pick      = crd_pkg::NUM_EVT'(1) << i;
				nxt.index = crd_pkg::IDX_W'(i);
			end
		end
		rest = enc_pend_s2 & ~pick;
		if (btn_pend_s2) begin
			nxt.kind  = crd_pkg::KIND_BUTTON;
			nxt.index = btn_index_s2;
			nxt.value = btn_value_s2;
			nxt.last  = 1'b1;
		end else begin
			nxt.kind  = crd_pkg::KIND_ENCODER;
			nxt.value = |(enc_up_s2 & pick);
			nxt.last  = (rest == '0);
		end
	end

	assign free = !busy || (emit && nxt.last);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			btn_pend_s2 <= 1'b0;
			enc_pend_s2 <= '0;
		end else if (load) begin
			btn_pend_s2 <= dec.btn_hit;
			enc_pend_s2 <= dec.enc_chg;
		end else if (emit) begin
			btn_pend_s2 <= 1'b0;
			enc_pend_s2 <= rest;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			btn_index_s2 <= dec.btn_index;
			btn_value_s2 <= dec.btn_value;
			enc_up_s2    <= dec.enc_up;
			shift_s2     <= dec.shift;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= busy;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) out_q <= nxt;
	end

	assign evt.valid       = out_valid_q;
	assign evt.event_kind  = out_q.kind;
	assign evt.event_index = out_q.index;
	assign evt.event_value = out_q.value;
	assign evt.shift_held  = out_q.shift;
	assign evt.last_event  = out_q.last;

	a_no_load_while_busy: assert property (@(posedge clk) disable iff (!arst_n)
		load |-> free)
		else $error("report loaded over pending events");

	a_nonlast_keeps_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(emit && !nxt.last) |=> busy)
		else $error("queue emptied before last event");

	a_button_is_single: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_q.kind == crd_pkg::KIND_BUTTON) |-> out_q.last)
		else $error("button event not marked last");

	a_button_alone: assert property (@(posedge clk) disable iff (!arst_n)
		btn_pend_s2 |-> enc_pend_s2 == '0)
		else $error("button and encoder events queued together");

endmodule

### rtl/control_report_event_decoder_unit.sv
// Control report event decoder: top level with input register, decoder and event queue.
// The first event of a report passes the input register and the event queue before the output register.
// A report causes 1 to 9 events and holds the event queue until its last event leaves;
// a report with no change yields nothing and never enters the event queue.
// Events leave one per cycle while the sink is ready; the input register takes a new report while one drains.
// Reset (arst_n low, async) clears known buttons and encoders and empties all stages.
module control_report_event_decoder_unit #(
	parameter int NUM_BUTTONS  = crd_pkg::NUM_BUTTONS_DEF,
	parameter int NUM_ENCODERS = crd_pkg::NUM_ENCODERS_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	crd_report_if.sink   rpt,
	crd_event_if.source  evt
);

	// input register
	logic              valid_s1;
	crd_pkg::report_t  rpt_s1;

	crd_pkg::decode_t  dec;
	logic              q_free;
	logic              advance;
	logic              load;

	// a report moves into the queue as soon as the previous one has sent its last event
	assign advance   = valid_s1 && q_free;
	assign rpt.ready = !valid_s1 || q_free;
	// reports that change nothing are dropped here, no event slot used
	assign load      = advance && (dec.btn_hit || (|dec.enc_chg));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rpt.ready) begin
			valid_s1 <= rpt.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rpt.valid && rpt.ready) begin
			rpt_s1.button_bits  <= rpt.button_bits;
			rpt_s1.main_encoder <= rpt.main_encoder;
			rpt_s1.enc_pos      <= {rpt.enc_pos_h, rpt.enc_pos_g, rpt.enc_pos_f,
				rpt.enc_pos_e, rpt.enc_pos_d, rpt.enc_pos_c, rpt.enc_pos_b, rpt.enc_pos_a};
		end
	end

	// known state is updated when the report leaves the input register
	crd_decode #(
		.NUM_BUTTONS  (NUM_BUTTONS),
		.NUM_ENCODERS (NUM_ENCODERS)
	) u_decode (
		.clk    (clk),
		.arst_n (arst_n),
		.rpt_s1 (rpt_s1),
		.commit (advance),
		.dec    (dec)
	);

	crd_emit u_emit (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (load),
		.dec    (dec),
		.free   (q_free),
		.evt    (evt)
	);

	a_accept_only_when_room: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !q_free) |-> !rpt.ready)
		else $error("input register overwritten while held");

	a_held_report_advances: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && q_free && !rpt.valid) |=> !valid_s1)
		else $error("input register did not drain");

	a_load_needs_report: assert property (@(posedge clk) disable iff (!arst_n)
		load |-> valid_s1)
		else $error("event queue loaded without a report");

endmodule
